// ----- rtl/gsd_pkg.sv -----
package gsd_pkg;

    typedef struct packed {
        logic               kind;
        logic signed [31:0] base_category;
        logic signed [15:0] cover_value;
        logic        [23:0] cell_count;
    } t_in_req;

    typedef struct packed {
        logic signed [31:0] zone_category;
        logic        [23:0] std_deviation;
        logic        [1:0]  status;
    } t_out_req;

    typedef struct packed {
        logic               open;
        logic signed [31:0] zone;
        logic        [31:0] total;
        logic signed [47:0] value_sum;
        logic        [63:0] square_sum;
    } t_group;

    typedef struct packed {
        logic   valid;
        t_group group;
    } t_push;

    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_END  = 1'b1;

    localparam logic [1:0] STATUS_VALID  = 2'd0;
    localparam logic [1:0] STATUS_SINGLE = 2'd1;
    localparam logic [1:0] STATUS_EMPTY  = 2'd2;

    localparam logic [23:0] STD_MAX = 24'hFFFFFF;

endpackage

// ----- rtl/gsd_front.sv -----
module gsd_front #(
    parameter int VALUE_BITS = 16,
    parameter int TOTAL_BITS = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  gsd_pkg::t_in_req i_in_req,
    output gsd_pkg::t_push   o_push,
    input  logic             i_push_ready
);

    localparam int SH = 16 - VALUE_BITS;
    localparam logic [TOTAL_BITS-1:0] CAP = {TOTAL_BITS{1'b1}};

    logic                  r_open;
    logic signed [31:0]    r_zone;
    logic [TOTAL_BITS-1:0] r_total;
    logic signed [47:0]    r_sx;
    logic [63:0]           r_sxx;

    logic                  r_v0, r_v1, r_v2;
    logic signed [15:0]    r_v;
    logic [23:0]           r_w, r_w1;
    logic signed [40:0]    r_vw;
    logic [31:0]           r_vv;
    logic [55:0]           r_sqw;

    logic                  closing, busy, accept, is_end;
    logic signed [15:0]    v_shift, v_val;
    logic [TOTAL_BITS-1:0] total_base, remain;
    logic [23:0]           w_clip;
    logic signed [40:0]    n_vw;
    logic signed [31:0]    n_vv;

    assign is_end   = (i_in_req.kind == gsd_pkg::KIND_END);
    assign closing  = is_end || (r_open && (i_in_req.base_category != r_zone));
    assign busy     = r_v0 || r_v1 || r_v2;
    assign o_in_ready = !closing || (!busy && i_push_ready);
    assign accept   = i_in_valid && o_in_ready;

    assign v_shift  = i_in_req.cover_value <<< SH;
    assign v_val    = v_shift >>> SH;

    assign total_base = (closing || !r_open) ? '0 : r_total;
    assign remain     = CAP - total_base;
    assign w_clip     = ({8'd0, i_in_req.cell_count} > 32'(remain)) ?
                        24'(remain) : i_in_req.cell_count;

    assign n_vw = r_v * $signed({1'b0, r_w});
    assign n_vv = r_v * r_v;

    assign o_push.valid            = accept && closing;
    assign o_push.group.open       = r_open;
    assign o_push.group.zone       = r_zone;
    assign o_push.group.total      = 32'(r_total);
    assign o_push.group.value_sum  = r_sx;
    assign o_push.group.square_sum = r_sxx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open  <= 1'b0;
            r_zone  <= '0;
            r_total <= '0;
            r_sx    <= '0;
            r_sxx   <= '0;
            r_v0    <= 1'b0;
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
        end else begin
            r_v0 <= accept && !is_end;
            r_v1 <= r_v0;
            r_v2 <= r_v1;
            if (accept && is_end) begin
                r_open  <= 1'b0;
                r_zone  <= '0;
                r_total <= '0;
            end else if (accept) begin
                if (closing || !r_open) begin
                    r_open <= 1'b1;
                    r_zone <= i_in_req.base_category;
                end
                r_total <= total_base + TOTAL_BITS'(w_clip);
            end
            if (accept && closing) begin
                r_sx  <= '0;
                r_sxx <= '0;
            end else begin
                if (r_v1) begin
                    r_sx <= r_sx + 48'(r_vw);
                end
                if (r_v2) begin
                    r_sxx <= r_sxx + 64'(r_sqw);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_v   <= v_val;
        r_w   <= w_clip;
        r_vw  <= n_vw;
        r_vv  <= 32'(n_vv);
        r_w1  <= r_w;
        r_sqw <= r_vv * r_w1;
    end

    a_push_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push.valid |-> !busy)
        else $error("Group closed while accumulation was in flight.");

    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && is_end) |=> (!r_open && r_total == '0 && r_sx == '0))
        else $error("End request did not clear the group.");

endmodule

// ----- rtl/gsd_queue.sv -----
module gsd_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  gsd_pkg::t_push  i_push,
    output logic            o_push_ready,
    output logic            o_valid,
    output gsd_pkg::t_group o_group,
    input  logic            i_pop
);

    localparam int DEPTH = 2;
    localparam int AW    = $clog2(DEPTH);

    gsd_pkg::t_group r_mem [DEPTH];
    logic [AW-1:0]   r_wp, r_rp;
    logic [AW:0]     r_cnt;
    logic            push, pop;

    assign o_push_ready = (r_cnt != (AW+1)'(DEPTH));
    assign o_valid      = (r_cnt != '0);
    assign o_group      = r_mem[r_rp];
    assign push         = i_push.valid && o_push_ready;
    assign pop          = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (AW+1)'(push) - (AW+1)'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_push.group;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push.valid |-> o_push_ready)
        else $error("Group pushed into a full queue.");

endmodule

// ----- rtl/gsd_back.sv -----
module gsd_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  gsd_pkg::t_group   i_group,
    output logic              o_pop,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output gsd_pkg::t_out_req o_out_req
);

    typedef enum logic [2:0] {S_IDLE, S_MUL, S_CHK, S_DIV, S_SQRT, S_OUT} t_state;
    typedef enum logic [2:0] {
        OP_NSXX_LO, OP_NSXX_HI, OP_SQ_LL, OP_SQ_LH, OP_SQ_HH, OP_DEN, OP_NONE
    } t_op;

    t_state       r_state;
    t_op          r_op, r_pop_op;
    logic         r_pv;
    logic [31:0]  r_n;
    logic [47:0]  r_m;
    logic [63:0]  r_sxx;
    logic [63:0]  r_prod;
    logic [95:0]  r_acc;
    logic [63:0]  r_den;
    logic [63:0]  r_rem;
    logic [47:0]  r_num;
    logic [47:0]  r_res, r_bit;
    logic [5:0]   r_cnt;
    logic         r_valid;
    gsd_pkg::t_out_req r_out;

    logic [31:0]  mul_a, mul_b;
    logic [95:0]  prod_w;
    logic [64:0]  div_t;
    logic [47:0]  sq_trial;
    logic [47:0]  m_abs;

    assign o_out_valid = r_valid;
    assign o_out_req   = r_out;
    assign o_pop       = (r_state == S_IDLE) && i_valid;
    assign m_abs       = (i_group.value_sum < 0) ? 48'(-i_group.value_sum) :
                         48'(i_group.value_sum);
    assign prod_w      = {32'd0, r_prod};
    assign div_t       = {r_rem, r_num[47]};
    assign sq_trial    = r_res + r_bit;

    always_comb begin
        mul_a = r_n;
        mul_b = r_sxx[31:0];
        unique case (r_op)
            OP_NSXX_LO: begin
                mul_a = r_n;
                mul_b = r_sxx[31:0];
            end
            OP_NSXX_HI: begin
                mul_a = r_n;
                mul_b = r_sxx[63:32];
            end
            OP_SQ_LL: begin
                mul_a = r_m[31:0];
                mul_b = r_m[31:0];
            end
            OP_SQ_LH: begin
                mul_a = r_m[31:0];
                mul_b = {16'd0, r_m[47:32]};
            end
            OP_SQ_HH: begin
                mul_a = {16'd0, r_m[47:32]};
                mul_b = {16'd0, r_m[47:32]};
            end
            OP_DEN: begin
                mul_a = r_n;
                mul_b = r_n - 32'd1;
            end
            default: begin
                mul_a = r_n;
                mul_b = r_sxx[31:0];
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
            r_op    <= OP_NONE;
            r_pv    <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_n   <= i_group.total;
                        r_m   <= m_abs;
                        r_sxx <= i_group.square_sum;
                        r_acc <= '0;
                        r_pv  <= 1'b0;
                        r_op  <= OP_NSXX_LO;
                        r_out.zone_category <= i_group.open ? i_group.zone : '0;
                        r_out.std_deviation <= '0;
                        if (i_group.total == 32'd0) begin
                            r_out.status <= gsd_pkg::STATUS_EMPTY;
                            r_state      <= S_OUT;
                        end else if (i_group.total == 32'd1) begin
                            r_out.status <= gsd_pkg::STATUS_SINGLE;
                            r_state      <= S_OUT;
                        end else begin
                            r_out.status <= gsd_pkg::STATUS_VALID;
                            r_state      <= S_MUL;
                        end
                    end
                end
                S_MUL: begin
                    r_prod   <= mul_a * mul_b;
                    r_pop_op <= r_op;
                    r_pv     <= (r_op != OP_NONE);
                    if (r_op != OP_NONE) begin
                        r_op <= t_op'(r_op + 3'd1);
                    end
                    if (r_pv) begin
                        unique case (r_pop_op)
                            OP_NSXX_LO: r_acc <= r_acc + prod_w;
                            OP_NSXX_HI: r_acc <= r_acc + (prod_w << 32);
                            OP_SQ_LL:   r_acc <= r_acc - prod_w;
                            OP_SQ_LH:   r_acc <= r_acc - (prod_w << 33);
                            OP_SQ_HH:   r_acc <= r_acc - (prod_w << 64);
                            OP_DEN: begin
                                r_den   <= r_prod;
                                r_state <= S_CHK;
                            end
                            default: r_acc <= r_acc;
                        endcase
                    end
                end
                S_CHK: begin
                    if (r_acc[95:32] >= r_den) begin
                        r_out.std_deviation <= gsd_pkg::STD_MAX;
                        r_state             <= S_OUT;
                    end else begin
                        r_rem   <= r_acc[95:32];
                        r_num   <= {r_acc[31:0], 16'd0};
                        r_cnt   <= 6'd47;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (div_t >= {1'b0, r_den}) begin
                        r_rem <= 64'(div_t - {1'b0, r_den});
                        r_num <= {r_num[46:0], 1'b1};
                    end else begin
                        r_rem <= div_t[63:0];
                        r_num <= {r_num[46:0], 1'b0};
                    end
                    if (r_cnt == 6'd0) begin
                        r_res   <= '0;
                        r_bit   <= 48'd1 << 46;
                        r_cnt   <= 6'd23;
                        r_state <= S_SQRT;
                    end else begin
                        r_cnt <= r_cnt - 6'd1;
                    end
                end
                S_SQRT: begin
                    if (r_num >= sq_trial) begin
                        r_num <= r_num - sq_trial;
                        r_res <= (r_res >> 1) + r_bit;
                    end else begin
                        r_res <= r_res >> 1;
                    end
                    r_bit <= r_bit >> 2;
                    if (r_cnt == 6'd0) begin
                        r_state <= S_OUT;
                    end else begin
                        r_cnt <= r_cnt - 6'd1;
                    end
                end
                S_OUT: begin
                    if (r_out.status == gsd_pkg::STATUS_VALID &&
                        r_out.std_deviation != gsd_pkg::STD_MAX && !r_valid) begin
                        r_out.std_deviation <= r_res[23:0];
                    end
                    if (!r_valid) begin
                        r_valid <= 1'b1;
                    end else if (i_out_ready) begin
                        r_valid <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_den_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_den != '0))
        else $error("Division started with a zero divisor.");

    a_out_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_out.status != gsd_pkg::STATUS_VALID) |->
        (r_out.std_deviation == '0))
        else $error("Deviation set on a group without enough samples.");

endmodule

// ----- rtl/grouped_sample_std_deviation_core.sv -----
// Computes the count-weighted sample standard deviation of each base category group
// in a stream of tuples sorted by category, as unsigned Q16.8 with saturation. Data
// tuples are accumulated at one per cycle through a three-stage multiply-add pipeline;
// a tuple that closes a group waits for that pipeline to drain and for room in the
// two-entry queue, then hands the group's sums to it. The back end takes one group at
// a time (six shared 32x32 multiplies, a 48-step radix-2 division and a 24-step square
// root, skipped for a group with fewer than two samples) and pops the next only after
// the result is taken, so the divider and square-root sequencer set the group rate.
module grouped_sample_std_deviation_core #(
    parameter int VALUE_BITS = 16,
    parameter int TOTAL_BITS = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  gsd_pkg::t_in_req  i_in_req,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output gsd_pkg::t_out_req o_out_req
);

    gsd_pkg::t_push  push;
    gsd_pkg::t_group q_group;
    logic            push_ready, q_valid, q_pop;

    gsd_front #(
        .VALUE_BITS(VALUE_BITS),
        .TOTAL_BITS(TOTAL_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_in_req     (i_in_req),
        .o_push       (push),
        .i_push_ready (push_ready)
    );

    gsd_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .o_push_ready (push_ready),
        .o_valid      (q_valid),
        .o_group      (q_group),
        .i_pop        (q_pop)
    );

    gsd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (q_valid),
        .i_group     (q_group),
        .o_pop       (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_req   (o_out_req)
    );

endmodule
